// ===== rtl/core/pwl_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
// Used by pwl_cell, pwl_div and piecewise_linear_interp.
package pwl_pkg;

  localparam int DATA_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int IDX_W      = 4;
  localparam int CFG_W      = 5;
  localparam int POINTS_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // Query token handed from cell to cell.
  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic                     interp;
    logic                     in_range;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] qx;
    logic signed [DATA_W-1:0] xa;
    logic signed [DATA_W-1:0] xb;
    logic signed [DATA_W-1:0] ya;
    logic signed [DATA_W-1:0] yb;
  } pwl_tok_t;

endpackage

// ===== rtl/core/pwl_cell.sv =====
// One breakpoint cell: holds an (x, y) pair and checks the passing query token
// against its own segment. Depends on pwl_pkg.
module pwl_cell
  import pwl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic signed [DATA_W-1:0] wr_x,
  input  logic signed [DATA_W-1:0] wr_y,
  input  logic [SLOT_W-1:0]        slot_id,
  input  logic                     pair_ok,
  input  logic signed [DATA_W-1:0] nb_x,
  input  logic signed [DATA_W-1:0] nb_y,
  input  pwl_tok_t                 tok_in,
  output pwl_tok_t                 tok_out,
  output logic signed [DATA_W-1:0] x_q,
  output logic signed [DATA_W-1:0] y_q
);

  pwl_tok_t tok_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_q <= wr_x;
      y_q <= wr_y;
    end
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.done) begin
      if (pair_ok) begin
        if (tok_in.qx == x_q) begin
          tok_next.done     = 1'b1;
          tok_next.in_range = 1'b1;
          tok_next.slot     = slot_id;
          tok_next.ya       = y_q;
        end else if (x_q < tok_in.qx && tok_in.qx < nb_x) begin
          tok_next.done     = 1'b1;
          tok_next.interp   = 1'b1;
          tok_next.in_range = 1'b1;
          tok_next.slot     = slot_id;
          tok_next.xa       = x_q;
          tok_next.xb       = nb_x;
          tok_next.ya       = y_q;
          tok_next.yb       = nb_y;
        end
      end else begin
        // last active point: clamp high
        tok_next.done     = 1'b1;
        tok_next.in_range = (tok_in.qx == x_q);
        tok_next.slot     = slot_id;
        tok_next.ya       = y_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/pwl_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend whose high
// half is below the divisor, 32-bit divisor and quotient. Depends on pwl_pkg.
module pwl_div
  import pwl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*DATA_W-1:0]   dividend,
  input  logic [DATA_W-1:0]     divisor,
  output logic                  done,
  output logic [DATA_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign trial = {rem, lo[DATA_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[2*DATA_W-1:DATA_W];
      lo    <= dividend[DATA_W-1:0];
      den_r <= divisor;
      cnt   <= '1;
    end else if (busy) begin
      rem      <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo       <= {lo[DATA_W-2:0], 1'b0};
      quotient <= {quotient[DATA_W-2:0], ge};
      cnt      <= cnt - CNT_W'(1);
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den_r)
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("divider done without a run");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/piecewise_linear_interp.sv =====
// Piecewise linear interpolator over a chain of POINTS breakpoint cells.
// Load beats are taken back to back while idle. A query token walks the chain
// of cell registers; a clamped or exact result then goes straight to DONE, an
// interpolated one passes through prep, multiply and the divider first.
// One query in flight: no new beat is taken until the result is loaded.
// rst clears control, count register to 2; table contents are not cleared.
module piecewise_linear_interp
  import pwl_pkg::*;
#(
  parameter int POINTS = POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] entry_x,
  input  logic signed [DATA_W-1:0] entry_y,
  input  logic signed [DATA_W-1:0] query_x,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] result_y,
  output logic                     in_range,
  output logic [SLOT_W-1:0]        lower_slot
);

  localparam int CW = $clog2(POINTS + 1);

  state_t state, state_next;

  logic [CFG_W-1:0] points_in_use;
  logic [CW-1:0]    cnt;

  pwl_tok_t                 tok [POINTS+1];
  logic signed [DATA_W-1:0] cell_x [POINTS];
  logic signed [DATA_W-1:0] cell_y [POINTS];

  logic accept_in;
  logic query_go;
  logic load_go;
  logic div_start;
  logic div_done;
  logic out_load;

  logic signed [DATA_W-1:0] t_y;
  logic signed [DATA_W-1:0] t_yb;
  logic signed [DATA_W-1:0] t_qx;
  logic signed [DATA_W-1:0] t_xa;
  logic signed [DATA_W-1:0] t_xb;
  logic                     t_ok;
  logic [SLOT_W-1:0]        t_slot;

  logic [DATA_W:0]     dy;
  logic                neg;
  logic [DATA_W-1:0]   mag;
  logic [DATA_W-1:0]   num;
  logic [DATA_W-1:0]   den;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   quo;

  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign query_go  = accept_in && (action == ACT_QUERY);
  assign load_go   = accept_in && (action == ACT_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= CFG_RESET;
    end else if (cfg_wr_en) begin
      points_in_use <= cfg_wr_data;
    end
  end

  always_comb begin
    if (points_in_use == '0) begin
      cnt = CW'(1);
    end else if (32'(points_in_use) > POINTS) begin
      cnt = CW'(POINTS);
    end else begin
      cnt = CW'(points_in_use);
    end
  end

  // Query entry; below-first check happens here against cell 0.
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = query_go;
    tok[0].done     = (query_x < cell_x[0]);
    tok[0].qx       = query_x;
    tok[0].xa       = cell_x[0];
    tok[0].xb       = cell_x[0];
    tok[0].ya       = cell_y[0];
    tok[0].yb       = cell_y[0];
  end

  for (genvar i = 0; i < POINTS; i++) begin : g_cell
    logic                     wr_en;
    logic                     pair_ok;
    logic signed [DATA_W-1:0] nb_x;
    logic signed [DATA_W-1:0] nb_y;

    assign wr_en   = load_go && (32'(entry_index) == i);
    assign pair_ok = (CW'(i + 1) < cnt);

    if (i < POINTS - 1) begin : g_nb
      assign nb_x = cell_x[i+1];
      assign nb_y = cell_y[i+1];
    end else begin : g_end
      assign nb_x = cell_x[i];
      assign nb_y = cell_y[i];
    end

    pwl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en),
      .wr_x    (entry_x),
      .wr_y    (entry_y),
      .slot_id (SLOT_W'(i)),
      .pair_ok (pair_ok),
      .nb_x    (nb_x),
      .nb_y    (nb_y),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .x_q     (cell_x[i]),
      .y_q     (cell_y[i])
    );
  end

  pwl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (query_go) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[POINTS].valid) begin
          state_next = tok[POINTS].interp ? ST_PREP : ST_DONE;
        end
      end
      ST_PREP: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign dy   = {t_yb[DATA_W-1], t_yb} - {t_y[DATA_W-1], t_y};
  // product goes straight into the divider registers
  assign prod = (2*DATA_W)'(mag) * (2*DATA_W)'(num);

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tok[POINTS].valid) begin
      t_y    <= tok[POINTS].ya;
      t_yb   <= tok[POINTS].yb;
      t_qx   <= tok[POINTS].qx;
      t_xa   <= tok[POINTS].xa;
      t_xb   <= tok[POINTS].xb;
      t_ok   <= tok[POINTS].in_range;
      t_slot <= tok[POINTS].slot;
    end
    if (state == ST_PREP) begin
      neg <= dy[DATA_W];
      mag <= dy[DATA_W] ? DATA_W'(-dy) : DATA_W'(dy);
      num <= t_qx - t_xa;
      den <= t_xb - t_xa;
    end
    if (state == ST_DIV && div_done) begin
      t_y <= neg ? (t_y - $signed(quo)) : (t_y + $signed(quo));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_y   <= t_y;
      in_range   <= t_ok;
      lower_slot <= t_slot;
    end
  end

  a_tok_reaches_tail: assert property (@(posedge clk) disable iff (rst)
    query_go |-> ##POINTS tok[POINTS].valid)
    else $error("query token lost in cell chain");

  a_tail_resolved: assert property (@(posedge clk) disable iff (rst)
    tok[POINTS].valid |-> tok[POINTS].done)
    else $error("query token left chain unresolved");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide phase");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_load |-> state == ST_DONE && !(out_valid && out_stall))
    else $error("result overwrote a pending beat");

endmodule
